// ===== src/cld_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cld_pkg: shared constants and types of the C-LOOK disk scheduler
// Defaults for the top-level parameters, field widths, register indexes and
// the control bundles passed from the top level to its cells and selector.
// ============================================================================
package cld_pkg;

    localparam int DEF_MAX_REQUESTS = 32;
    localparam int DEF_TRACK_BITS   = 16;
    localparam int SEEK_BITS        = 22;
    localparam int CFG_DATA_BITS    = 16;
    localparam int CFG_INDEX_BITS   = 1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_START_HEAD = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SWEEP_DOWN = 1'b1;

    // ring stage control
    typedef struct packed {
        logic shift;   // take the entry from the neighbor
        logic clear;   // drop the entry (end of batch)
    } cld_cell_ctl_t;

    // selector control
    typedef struct packed {
        logic scan;    // an entry leaves the ring tail this cycle
        logic first;   // first cycle of a rotation
    } cld_sel_ctl_t;

endpackage

// ===== src/cld_cell.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cld_cell: one stage of the request ring
// Holds one stored request (track, load index, valid) and hands it to the
// next stage whenever the ring shifts.
// ============================================================================
module cld_cell
    import cld_pkg::*;
#(
    parameter int TRACK_BITS = DEF_TRACK_BITS,
    parameter int IDX_BITS   = 5
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cld_cell_ctl_t         ctl,
    input  logic                  din_valid,
    input  logic [TRACK_BITS-1:0] din_track,
    input  logic [IDX_BITS-1:0]   din_idx,
    output logic                  dout_valid,
    output logic [TRACK_BITS-1:0] dout_track,
    output logic [IDX_BITS-1:0]   dout_idx
);

    logic                  valid_reg;
    logic [TRACK_BITS-1:0] track_reg;
    logic [IDX_BITS-1:0]   idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.shift)
        begin
            valid_reg <= din_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            track_reg <= din_track;
            idx_reg   <= din_idx;
        end
    end

    assign dout_valid = valid_reg;
    assign dout_track = track_reg;
    assign dout_idx   = idx_reg;

endmodule

// ===== src/cld_select.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cld_select: next-request picker at the ring tail
// Compares each entry leaving the ring against the best seen so far in the
// current rotation. Order: in-sweep side first, then track in sweep order,
// then load order.
// ============================================================================
module cld_select
    import cld_pkg::*;
#(
    parameter int TRACK_BITS = DEF_TRACK_BITS,
    parameter int IDX_BITS   = 5
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cld_sel_ctl_t          ctl,
    input  logic [TRACK_BITS-1:0] origin,
    input  logic                  down,
    input  logic                  cand_live,
    input  logic [TRACK_BITS-1:0] cand_track,
    input  logic [IDX_BITS-1:0]   cand_idx,
    output logic [TRACK_BITS-1:0] best_track,
    output logic [IDX_BITS-1:0]   best_idx
);

    localparam int KEY_BITS = 1 + TRACK_BITS + IDX_BITS;

    logic                  found_reg;
    logic [KEY_BITS-1:0]   best_key_reg;
    logic [TRACK_BITS-1:0] best_track_reg;
    logic [IDX_BITS-1:0]   best_idx_reg;

    logic                  cand_wrap;
    logic [TRACK_BITS-1:0] cand_order;
    logic [KEY_BITS-1:0]   cand_key;
    logic                  take;

    always_comb
    begin
        // wrap side sorts after the in-sweep side
        cand_wrap  = down ? (cand_track > origin) : (cand_track < origin);
        cand_order = down ? ~cand_track : cand_track;
        cand_key   = {cand_wrap, cand_order, cand_idx};
        take       = cand_live && (ctl.first || !found_reg || (cand_key < best_key_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.scan)
        begin
            found_reg <= (found_reg && !ctl.first) || cand_live;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.scan && take)
        begin
            best_key_reg   <= cand_key;
            best_track_reg <= cand_track;
            best_idx_reg   <= cand_idx;
        end
    end

    assign best_track = best_track_reg;
    assign best_idx   = best_idx_reg;

endmodule

// ===== src/c_look_disk_scheduler_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// c_look_disk_scheduler_core: C-LOOK disk request scheduler
// Collects a batch of track requests and returns them in C-LOOK order with
// per-request head movement and running seek total.
// ============================================================================
// Usage: stream track requests in on s_axis, one per transfer, and mark the
// final one with s_axis_tlast. Requests are accepted back to back; requests
// past MAX_REQUESTS are dropped, but a dropped tlast still closes the batch.
// When the batch closes, start_head and sweep_down are sampled and the block
// stops taking input until the last result has been loaded into its output
// register. Results come out on m_axis, tlast on the final one. Each result
// takes one full rotation of the request ring past the tail comparator and
// then a load into the output register, which waits while the output is
// stalled. The output register lets the next batch start loading while the
// final result waits. Write configuration only while no batch is in
// service.
// ============================================================================
module c_look_disk_scheduler_core
    import cld_pkg::*;
#(
    parameter int MAX_REQUESTS = DEF_MAX_REQUESTS,
    parameter int TRACK_BITS   = DEF_TRACK_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    // configuration write port
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,

    // request stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [((TRACK_BITS+7)/8)*8-1:0] s_axis_tdata,  // track
    input  logic                      s_axis_tlast,        // last_request

    // result stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // served_track, move_distance, total_seek, zero pad
    output logic [((2*TRACK_BITS+SEEK_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic                      m_axis_tlast         // last_result
);

    localparam int OUT_BITS = ((2 * TRACK_BITS + SEEK_BITS + 7) / 8) * 8;
    localparam int IDX_BITS = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_BITS = $clog2(MAX_REQUESTS + 1);

    // one-hot controller states
    typedef enum logic [2:0] {
        ST_LOAD = 3'b001,   // taking requests
        ST_SCAN = 3'b010,   // ring rotating past the picker
        ST_PUT  = 3'b100    // winner goes to the output register
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [CFG_DATA_BITS-1:0] start_head_reg;
    logic                     sweep_down_reg;

    // batch state
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   remain_reg;
    logic [IDX_BITS-1:0]   scan_cnt_reg;
    logic [TRACK_BITS-1:0] origin_reg;
    logic                  down_reg;
    logic [TRACK_BITS-1:0] head_reg;
    logic [SEEK_BITS-1:0]  seek_reg;
    logic [IDX_BITS-1:0]   prev_idx_reg;
    logic                  have_prev_reg;

    // output register
    logic                  out_valid_reg;
    logic [TRACK_BITS-1:0] out_track_reg;
    logic [TRACK_BITS-1:0] out_dist_reg;
    logic [SEEK_BITS-1:0]  out_seek_reg;
    logic                  out_last_reg;

    // ring wiring
    logic                  cell_valid [MAX_REQUESTS];
    logic [TRACK_BITS-1:0] cell_track [MAX_REQUESTS];
    logic [IDX_BITS-1:0]   cell_idx   [MAX_REQUESTS];
    logic                  ring_in_valid;
    logic [TRACK_BITS-1:0] ring_in_track;
    logic [IDX_BITS-1:0]   ring_in_idx;
    cld_cell_ctl_t         cell_ctl;
    cld_sel_ctl_t          sel_ctl;

    logic                  in_xfer;
    logic                  has_room;
    logic                  tail_live;
    logic                  scan_end;
    logic                  out_free;
    logic                  put_fire;
    logic                  last_put;
    logic [TRACK_BITS-1:0] best_track;
    logic [IDX_BITS-1:0]   best_idx;
    logic [TRACK_BITS-1:0] dist_next;
    logic [SEEK_BITS-1:0]  seek_next;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_head_reg <= '0;
            sweep_down_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_HEAD: start_head_reg <= cfg_wdata;
                REG_SWEEP_DOWN: sweep_down_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    always_comb
    begin
        in_xfer   = s_axis_tvalid && s_axis_tready;
        has_room  = count_reg < CNT_BITS'(MAX_REQUESTS);
        // previous winner is dropped as it passes the tail
        tail_live = cell_valid[MAX_REQUESTS-1] &&
                    !(have_prev_reg && (cell_idx[MAX_REQUESTS-1] == prev_idx_reg));
        scan_end  = (state_reg == ST_SCAN) && (scan_cnt_reg == IDX_BITS'(MAX_REQUESTS - 1));
        out_free  = !out_valid_reg || m_axis_tready;
        put_fire  = (state_reg == ST_PUT) && out_free;
        last_put  = remain_reg == CNT_BITS'(1);

        dist_next = (best_track >= head_reg) ? (best_track - head_reg)
                                             : (head_reg - best_track);
        seek_next = seek_reg + SEEK_BITS'(dist_next);

        cell_ctl.shift = (in_xfer && has_room) || (state_reg == ST_SCAN);
        cell_ctl.clear = put_fire && last_put;
        sel_ctl.scan   = state_reg == ST_SCAN;
        sel_ctl.first  = scan_cnt_reg == '0;

        if (state_reg == ST_LOAD)
        begin
            ring_in_valid = 1'b1;
            ring_in_track = s_axis_tdata[TRACK_BITS-1:0];
            ring_in_idx   = count_reg[IDX_BITS-1:0];
        end
        else
        begin
            ring_in_valid = tail_live;
            ring_in_track = cell_track[MAX_REQUESTS-1];
            ring_in_idx   = cell_idx[MAX_REQUESTS-1];
        end

        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: if (in_xfer && s_axis_tlast) state_next = ST_SCAN;
            ST_SCAN: if (scan_end) state_next = ST_PUT;
            ST_PUT:  if (put_fire) state_next = last_put ? ST_LOAD : ST_SCAN;
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            remain_reg    <= '0;
            scan_cnt_reg  <= '0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == ST_LOAD && in_xfer)
            begin
                if (has_room)
                begin
                    count_reg <= count_reg + CNT_BITS'(1);
                end
                if (s_axis_tlast)
                begin
                    remain_reg    <= has_room ? (count_reg + CNT_BITS'(1)) : count_reg;
                    scan_cnt_reg  <= '0;
                    have_prev_reg <= 1'b0;
                end
            end

            if (state_reg == ST_SCAN)
            begin
                scan_cnt_reg <= scan_cnt_reg + IDX_BITS'(1);
            end

            if (put_fire)
            begin
                remain_reg    <= remain_reg - CNT_BITS'(1);
                scan_cnt_reg  <= '0;
                have_prev_reg <= 1'b1;
                if (last_put)
                begin
                    count_reg <= '0;
                end
            end

            if (put_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // batch datapath and output register
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD && in_xfer && s_axis_tlast)
        begin
            origin_reg <= TRACK_BITS'(start_head_reg);
            down_reg   <= sweep_down_reg;
            head_reg   <= TRACK_BITS'(start_head_reg);
            seek_reg   <= '0;
        end
        if (put_fire)
        begin
            head_reg      <= best_track;
            seek_reg      <= seek_next;
            prev_idx_reg  <= best_idx;
            out_track_reg <= best_track;
            out_dist_reg  <= dist_next;
            out_seek_reg  <= seek_next;
            out_last_reg  <= last_put;
        end
    end

    // ------------------------------------------------------------------
    // request ring: stage 0 takes new requests while loading and the
    // tail entry while rotating
    // ------------------------------------------------------------------
    for (genvar i = 0; i < MAX_REQUESTS; i++)
    begin : g_ring
        if (i == 0)
        begin : g_head
            cld_cell #(
                .TRACK_BITS (TRACK_BITS),
                .IDX_BITS   (IDX_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (cell_ctl),
                .din_valid  (ring_in_valid),
                .din_track  (ring_in_track),
                .din_idx    (ring_in_idx),
                .dout_valid (cell_valid[i]),
                .dout_track (cell_track[i]),
                .dout_idx   (cell_idx[i])
            );
        end
        else
        begin : g_body
            cld_cell #(
                .TRACK_BITS (TRACK_BITS),
                .IDX_BITS   (IDX_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (cell_ctl),
                .din_valid  (cell_valid[i-1]),
                .din_track  (cell_track[i-1]),
                .din_idx    (cell_idx[i-1]),
                .dout_valid (cell_valid[i]),
                .dout_track (cell_track[i]),
                .dout_idx   (cell_idx[i])
            );
        end
    end

    // picker at the ring tail
    cld_select #(
        .TRACK_BITS (TRACK_BITS),
        .IDX_BITS   (IDX_BITS)
    ) u_select (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (sel_ctl),
        .origin     (origin_reg),
        .down       (down_reg),
        .cand_live  (tail_live),
        .cand_track (cell_track[MAX_REQUESTS-1]),
        .cand_idx   (cell_idx[MAX_REQUESTS-1]),
        .best_track (best_track),
        .best_idx   (best_idx)
    );

    // ------------------------------------------------------------------
    // ports
    // ------------------------------------------------------------------
    assign s_axis_tready = state_reg == ST_LOAD;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = OUT_BITS'({out_seek_reg, out_dist_reg, out_track_reg});

endmodule

// ===== src/cld_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cld_checker: port-level checks for the C-LOOK scheduler
// Watches the stream ports for handshake and batch sequencing slips.
// ============================================================================
module cld_checker
    import cld_pkg::*;
#(
    parameter int OUT_BITS = 56
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                s_axis_tlast,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [OUT_BITS-1:0] m_axis_tdata,
    input logic                m_axis_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // no request is taken while a batch still has results to come
    a_busy_mid_batch: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input open in the middle of a batch");

    // closing a batch stops the input
    a_close_batch: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input still open after batch close");

    // input reopens only together with the final result of the batch
    a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && $rose(s_axis_tready) |-> m_axis_tvalid && m_axis_tlast)
        else $error("input reopened without the final result");

endmodule

bind c_look_disk_scheduler_core cld_checker #(
    .OUT_BITS (((2 * TRACK_BITS + cld_pkg::SEEK_BITS + 7) / 8) * 8)
) u_cld_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
